FILE: rtl/core/tal_pkg.sv
// shared types, constants and command/status structs for the time-at-length lookup
package tal_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  // divider geometry
  localparam int DVD_W       = 2 * DATA_W;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STEPS   = DVD_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_HI
  } rd_sel_t;

  // result source
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_TLAST,
    RES_TA,
    RES_FIX
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic         load_in;
    logic         do_append;
    logic         rd_en;
    rd_sel_t      rd_sel;
    logic         init_search;
    logic         step_search;
    logic         cap_lo;
    logic         calc_diff;
    logic         div_start;
    logic         res_load;
    res_sel_t     res_sel;
    status_code_t status_code;
    logic         out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_query;
    logic table_full;
    logic under_two;
    logic len_nonpos;
    logic len_ge_rd;
    logic span_gt1;
    logic dy_zero;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/time_at_length_lookup.sv
// top level: time lookup by path length over an appended sample table
// append: captured, written to the table, then its result loaded into the output register
// query: a binary search over the table, with a table read and a compare per step, then the
//   64 by 32 divider, before the result loads into the output register
// next request taken the cycle after the result loads into the output register
// reset clears the fill count and control; table contents stay undefined, no clearing pass
module time_at_length_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [tal_pkg::DATA_W-1:0]        sample_time,
  input  logic signed [tal_pkg::DATA_W-1:0] path_length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tal_pkg::DATA_W-1:0]        time_result,
  output logic [1:0]                        status
);
  import tal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  tal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tal_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .sample_time (sample_time),
    .path_length (path_length),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .time_result (time_result),
    .status      (status)
  );

  // a held result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register loaded while a result is held");

  // one request in work at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

  // failed requests carry a zero time
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (time_result == '0))
    else $error("nonzero time on a failed request");

  // divider only starts from an idle controller path, never while running
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

endmodule

FILE: rtl/core/tal_div.sv
// unsigned 64 by 32 restoring divider, two quotient bits per cycle
module tal_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tal_pkg::DVD_W-1:0]   dividend,
  input  logic [tal_pkg::DATA_W-1:0]  divisor,
  output logic                        busy,
  output logic [tal_pkg::DVD_W-1:0]   quotient
);
  import tal_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dvs;

  logic [DATA_W:0]      r1;
  logic [DATA_W:0]      r2;
  logic                 ge1;
  logic                 ge2;
  logic [DATA_W-1:0]    rem1;
  logic [DATA_W-1:0]    rem2;

  // two dependent compare-subtract steps
  always_comb begin
    r1   = {rem, dvd[DVD_W-1]};
    ge1  = (r1 >= {1'b0, dvs});
    rem1 = ge1 ? DATA_W'(r1 - {1'b0, dvs}) : r1[DATA_W-1:0];
    r2   = {rem1, dvd[DVD_W-2]};
    ge2  = (r2 >= {1'b0, dvs});
    rem2 = ge2 ? DATA_W'(r2 - {1'b0, dvs}) : r2[DATA_W-1:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run <= 1'b0;
      end
    end
  end

  // dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      dvd <= {dvd[DVD_W-3:0], ge1, ge2};
      rem <= rem2;
    end
  end

  assign busy     = run;
  assign quotient = dvd;

endmodule

FILE: rtl/core/tal_dpath.sv
// datapath: sample tables, search pointers, interpolation arithmetic, output register
module tal_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  tal_pkg::cmd_t                     cmd,
  output tal_pkg::sts_t                     sts,
  input  logic                              opcode,
  input  logic [tal_pkg::DATA_W-1:0]        sample_time,
  input  logic signed [tal_pkg::DATA_W-1:0] path_length,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [tal_pkg::DATA_W-1:0]        time_result,
  output logic [1:0]                        status
);
  import tal_pkg::*;

  // sample memories
  logic [DATA_W-1:0]        time_mem   [TABLE_DEPTH];
  logic signed [DATA_W-1:0] length_mem [TABLE_DEPTH];

  logic                     op_q;
  logic [DATA_W-1:0]        stime_q;
  logic signed [DATA_W-1:0] len_q;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         last;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic [IDX_W-1:0]         span;
  logic [IDX_W-1:0]         rd_addr;
  logic                     table_full;
  logic                     wr_en;

  logic [DATA_W-1:0]        time_rd;
  logic signed [DATA_W-1:0] len_rd;
  logic [DATA_W-1:0]        ta;
  logic signed [DATA_W-1:0] ya;

  logic [DATA_W:0]          dt;
  logic [DATA_W:0]          dl;
  logic [DATA_W:0]          dy;
  logic [DATA_W-1:0]        mt;
  logic [DATA_W-1:0]        ml;
  logic [DATA_W-1:0]        my;
  logic                     neg;

  logic                     div_busy;
  logic [DVD_W-1:0]         quot;
  logic [DATA_W+1:0]        q_sat;
  logic [DATA_W+2:0]        r_sum;
  logic [DATA_W-1:0]        fix_val;

  logic [DATA_W-1:0]        res;
  status_code_t             res_st;
  logic                     out_free;

  // magnitude of a 33-bit two's complement difference
  function automatic logic [DATA_W-1:0] mag33(input logic [DATA_W:0] d);
    logic [DATA_W:0] m;
    m = d[DATA_W] ? (~d + (DATA_W+1)'(1)) : d;
    return m[DATA_W-1:0];
  endfunction

  // input request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= opcode;
      stime_q <= sample_time;
      len_q   <= path_length;
    end
  end

  // fill count
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign wr_en      = cmd.do_append && !table_full;
  assign cnt_m1     = count - CNT_W'(1);
  assign last       = cnt_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // search pointers
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];
  assign span    = hi - lo;

  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      lo <= '0;
      hi <= last;
    end else if (cmd.step_search) begin
      if (len_q < len_rd) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST: rd_addr = last;
      RD_MID:  rd_addr = mid;
      RD_LO:   rd_addr = lo;
      RD_HI:   rd_addr = hi;
      default: rd_addr = last;
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[count[IDX_W-1:0]]   <= stime_q;
      length_mem[count[IDX_W-1:0]] <= len_q;
    end
    if (cmd.rd_en) begin
      time_rd <= time_mem[rd_addr];
      len_rd  <= length_mem[rd_addr];
    end
  end

  // lower bracket sample
  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      ta <= time_rd;
      ya <= len_rd;
    end
  end

  // differences against the lower sample; upper sample sits in the read registers
  assign dt = {1'b0, time_rd} - {1'b0, ta};
  assign dl = {len_q[DATA_W-1], len_q} - {ya[DATA_W-1], ya};
  assign dy = {len_rd[DATA_W-1], len_rd} - {ya[DATA_W-1], ya};

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      mt  <= mag33(dt);
      ml  <= mag33(dl);
      my  <= mag33(dy);
      neg <= dt[DATA_W] ^ dl[DATA_W] ^ dy[DATA_W];
    end
  end

  // product feeds the divider's dividend register
  tal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (DVD_W'(mt) * DVD_W'(ml)),
    .divisor  (my),
    .busy     (div_busy),
    .quotient (quot)
  );

  // clamp quotient, apply sign, saturate to unsigned 32 bits
  always_comb begin
    if (quot > DVD_W'(64'h2_0000_0000)) begin
      q_sat = (DATA_W+2)'(64'h2_0000_0000);
    end else begin
      q_sat = quot[DATA_W+1:0];
    end
    if (neg) begin
      r_sum = {3'b000, ta} - {1'b0, q_sat};
    end else begin
      r_sum = {3'b000, ta} + {1'b0, q_sat};
    end
    if (r_sum[DATA_W+2]) begin
      fix_val = '0;
    end else if (r_sum[DATA_W+1:DATA_W] != 2'b00) begin
      fix_val = '1;
    end else begin
      fix_val = r_sum[DATA_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st <= cmd.status_code;
      unique case (cmd.res_sel)
        RES_ZERO:  res <= '0;
        RES_TLAST: res <= time_rd;
        RES_TA:    res <= ta;
        RES_FIX:   res <= fix_val;
        default:   res <= '0;
      endcase
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      time_result <= res;
      status      <= res_st;
    end
  end

  // status to controller
  always_comb begin
    sts.op_query   = (op_q == OP_QUERY);
    sts.table_full = table_full;
    sts.under_two  = (count < CNT_W'(2));
    sts.len_nonpos = (len_q <= 0);
    sts.len_ge_rd  = (len_q >= len_rd);
    sts.span_gt1   = (span > IDX_W'(1));
    sts.dy_zero    = (len_rd == ya);
    sts.div_busy   = div_busy;
    sts.out_free   = out_free;
  end

endmodule

FILE: rtl/core/tal_ctrl.sv
// controller: sequences append, search, interpolation and result hand-off
module tal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tal_pkg::sts_t  sts,
  output tal_pkg::cmd_t  cmd
);
  import tal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAST,
    S_SRCH,
    S_CMP,
    S_RDLO,
    S_RDHI,
    S_MUL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  state_t state;

  // state register and transitions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (!sts.op_query || sts.under_two || sts.len_nonpos) begin
            state <= S_DONE;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= sts.len_ge_rd ? S_DONE : S_SRCH;
        end
        S_SRCH: begin
          state <= sts.span_gt1 ? S_CMP : S_RDLO;
        end
        S_CMP:  state <= S_SRCH;
        S_RDLO: state <= S_RDHI;
        S_RDHI: begin
          state <= sts.dy_zero ? S_DONE : S_MUL;
        end
        S_MUL:  state <= S_DIV;
        S_DIV: begin
          if (!sts.div_busy) state <= S_FIX;
        end
        S_FIX:  state <= S_DONE;
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_LAST;
    cmd.res_sel     = RES_ZERO;
    cmd.status_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_DISPATCH: begin
        if (!sts.op_query) begin
          cmd.do_append   = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.status_code = sts.table_full ? ST_FULL : ST_OK;
        end else if (sts.under_two) begin
          cmd.res_load    = 1'b1;
          cmd.status_code = ST_SHORT;
        end else if (sts.len_nonpos) begin
          cmd.res_load    = 1'b1;
        end else begin
          cmd.rd_en       = 1'b1;
          cmd.rd_sel      = RD_LAST;
        end
      end
      S_LAST: begin
        if (sts.len_ge_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_TLAST;
        end else begin
          cmd.init_search = 1'b1;
        end
      end
      S_SRCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sts.span_gt1 ? RD_MID : RD_LO;
      end
      S_CMP: begin
        cmd.step_search = 1'b1;
      end
      S_RDLO: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HI;
      end
      S_RDHI: begin
        cmd.calc_diff = 1'b1;
        if (sts.dy_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_TA;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_FIX: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_FIX;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: verif/tb.sv
// testbench for the time-at-length lookup: directed and random requests checked against a predictor
module tb;
  import tal_pkg::*;

  // expected results, computed from a private copy of the sample table
  class time_table_tracker;
    bit [31:0]        time_tab [TABLE_DEPTH];
    bit signed [31:0] len_tab [TABLE_DEPTH];
    int unsigned      count;
    bit [31:0]        want_time_q [$];
    status_code_t     want_status_q [$];
    int               mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return want_time_q.size();
    endfunction

    // time between two samples, truncating toward zero, saturated to 32 bits
    function bit [31:0] interp_time(bit signed [31:0] len, bit [31:0] ta, bit [31:0] tb,
                                    bit signed [31:0] ya, bit signed [31:0] yb);
      longint    lta, ltb, lln, lya, lyb, dt, dl, dy, r;
      bit        flip;
      bit [63:0] mt, ml, my, q;
      lta = ta;
      ltb = tb;
      lln = len;
      lya = ya;
      lyb = yb;
      dt = ltb - lta;
      dl = lln - lya;
      dy = lyb - lya;
      if (dy == 0)
        return ta;
      flip = 1'b0;
      if (dt < 0) begin
        mt = -dt;
        flip = ~flip;
      end else begin
        mt = dt;
      end
      if (dl < 0) begin
        ml = -dl;
        flip = ~flip;
      end else begin
        ml = dl;
      end
      if (dy < 0) begin
        my = -dy;
        flip = ~flip;
      end else begin
        my = dy;
      end
      q = (mt * ml) / my;
      if (q > 64'h2_0000_0000)
        q = 64'h2_0000_0000;
      r = flip ? lta - longint'(q) : lta + longint'(q);
      if (r < 0)
        return 32'h0;
      if (r > 64'sh0000_0000_FFFF_FFFF)
        return 32'hFFFF_FFFF;
      return r[31:0];
    endfunction

    // an accepted request: update the table and queue what the block must answer
    function void take_request(bit op, bit [31:0] stime, bit signed [31:0] len);
      bit [31:0]    res;
      status_code_t st;
      int unsigned  last, lo, hi, mid;
      res = 32'h0;
      st = ST_OK;
      if (op == OP_APPEND) begin
        if (count >= TABLE_DEPTH) begin
          st = ST_FULL;
        end else begin
          time_tab[count] = stime;
          len_tab[count] = len;
          count++;
        end
      end else if (count < 2) begin
        st = ST_SHORT;
      end else begin
        last = count - 1;
        if (len <= 0) begin
          res = 32'h0;
        end else if (len >= len_tab[last]) begin
          res = time_tab[last];
        end else begin
          lo = 0;
          hi = last;
          while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (len < len_tab[mid])
              hi = mid;
            else
              lo = mid;
          end
          res = interp_time(len, time_tab[lo], time_tab[hi], len_tab[lo], len_tab[hi]);
        end
      end
      want_time_q = {want_time_q, res};
      want_status_q = {want_status_q, st};
    endfunction

    // an accepted result against the oldest expectation
    function void check_lookup(logic [31:0] got_time, logic [1:0] got_status);
      bit [31:0]    exp_time;
      status_code_t exp_status;
      if (want_time_q.size() == 0) begin
        $display("%0t: unexpected result: time_result %h status %0d", $time, got_time,
                 got_status);
        mismatches++;
        return;
      end
      exp_time = want_time_q.pop_front();
      exp_status = want_status_q.pop_front();
      if (got_time !== exp_time || got_status !== exp_status) begin
        $display("%0t: mismatch: expected time_result %h status %0d, got time_result %h status %0d",
                 $time, exp_time, exp_status, got_time, got_status);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OP_APPEND;
  logic [DATA_W-1:0]        sample_time = '0;
  logic signed [DATA_W-1:0] path_length = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_W-1:0]        time_result;
  logic [1:0]               status;

  time_table_tracker board;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  longint            run_len = 64'h5_0000;
  longint            run_time = 64'h5_0000;

  time_at_length_lookup dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .sample_time (sample_time),
    .path_length (path_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .time_result (time_result),
    .status      (status)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_lookup(time_result, status);
  end

  // one request: optional idle gap, then hold until accepted
  task send_request(input bit op, input bit [31:0] t, input bit signed [31:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    sample_time <= t;
    path_length <= len;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    board.take_request(op, t, len);
    @(negedge clk);
  endtask

  // stop sending until every expected result is back, then let the block settle
  task drain;
    in_valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
    @(negedge clk);
  endtask

  // append with a length at or above the previous well-formed one
  task append_grown;
    bit [31:0] t;
    run_len = run_len + $urandom_range(0, 32'hF_FFFF);
    if (run_len > 64'h7FFF_FFFF)
      run_len = 64'h7FFF_FFFF;
    run_time = run_time + $urandom_range(0, 32'h3F_FFFF);
    if (run_time > 64'hFFFF_FFFF)
      run_time = 64'hFFFF_FFFF;
    t = ($urandom_range(0, 7) == 0) ? $urandom : run_time[31:0];
    send_request(OP_APPEND, t, run_len[31:0]);
  endtask

  // query on, near, or away from a stored length
  task query_near;
    int unsigned      i;
    bit signed [31:0] q;
    if (board.count == 0) begin
      q = $urandom;
    end else begin
      i = $urandom_range(0, board.count - 1);
      case ($urandom_range(0, 3))
        0: q = board.len_tab[i];
        1: q = board.len_tab[i] + $urandom_range(1, 32'hF_FFFF);
        2: q = $urandom_range(1, 32'hFFFF);
        default: q = $urandom;
      endcase
    end
    send_request(OP_QUERY, $urandom, q);
  endtask

  task random_requests(input int n);
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_request(1'($urandom_range(0, 1)), $urandom, $urandom);
      else if (pick < 55)
        append_grown();
      else
        query_near();
    end
  endtask

  // directed corners; the first two lengths are out of order and close together,
  // so small queries bracket them and push the result past the top of the range
  task directed_requests;
    send_request(OP_QUERY, 32'h0, 32'h0001_0000);
    send_request(OP_APPEND, 32'h0, 32'h0001_8000);
    send_request(OP_QUERY, 32'hFFFF_FFFF, 32'h0000_8000);
    send_request(OP_APPEND, 32'hFFFF_FFFF, 32'h0001_0000);
    send_request(OP_QUERY, 32'h0, 32'h0000_8000);
    send_request(OP_QUERY, 32'h0, 32'h0000_0001);
    send_request(OP_QUERY, 32'h0, 32'h0);
    send_request(OP_QUERY, 32'h0, 32'h8000_0000);
    send_request(OP_QUERY, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h0, 32'h7FFF_FFFF);
    send_request(OP_QUERY, 32'h0, 32'h0001_0000);
    send_request(OP_APPEND, 32'h0001_0000, 32'h0002_0000);
    send_request(OP_APPEND, 32'h0000_8000, 32'h0003_0000);
    send_request(OP_APPEND, 32'h0004_0000, 32'h0003_0000);
    send_request(OP_APPEND, 32'h0005_0000, 32'h0005_0000);
    send_request(OP_QUERY, 32'h0, 32'h0001_8000);
    send_request(OP_QUERY, 32'h0, 32'h0002_8000);
    send_request(OP_QUERY, 32'h0, 32'h0003_0000);
    send_request(OP_QUERY, 32'h0, 32'h0004_FFFF);
    send_request(OP_QUERY, 32'h0, 32'h0002_0000);
    send_request(OP_QUERY, 32'h0, 32'h0000_C000);
  endtask

  // main sequence
  initial begin
    board = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_requests();
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_requests(180);
    drain();

    send_idle_pct = 74;
    recv_stall_pct = 0;
    random_requests(180);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 74;
    random_requests(180);
    drain();

    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_requests(180);
    drain();

    if (board.pending() != 0)
      $display("%0t: %0d results never arrived", $time, board.pending());
    if (board.mismatches == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: time_at_length_lookup.f
rtl/core/tal_pkg.sv
rtl/core/tal_div.sv
rtl/core/tal_dpath.sv
rtl/core/tal_ctrl.sv
rtl/core/time_at_length_lookup.sv
verif/tb.sv
